### rtl/core/fesr_pkg.sv
// Shared types and constants for the friction elastic slip return block.
package fesr_pkg;

  // Field widths
  localparam int MAX_DIM = 3;
  localparam int GAP_W   = 32;
  localparam int LEN_W   = 31;
  localparam int MU_W    = 16;
  localparam int PRS_W   = 32;

  // Internal widths
  localparam int CAP_W      = MU_W + PRS_W;
  localparam int CAP_LO_W   = 24;
  localparam int CAP_HI_W   = CAP_W - CAP_LO_W;
  localparam int MAG_W      = 32;
  localparam int SUM_W      = 64;
  localparam int LSQ_W      = 2 * LEN_W;
  localparam int UNIT_BITS  = 30;
  localparam int U_W        = UNIT_BITS + 1;
  localparam int NUM_W      = MAG_W + 1;
  localparam int DEN_W      = 32;
  localparam int HALF_W     = 5;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int DIV_STEPS  = U_W;
  localparam int PH_W       = CAP_HI_W + U_W;
  localparam int PL_W       = CAP_LO_W + U_W;
  localparam int PG_W       = LEN_W + U_W;
  localparam int X_W        = PH_W + 1;
  localparam int MULT_SHIFT = 18;
  localparam int MAGX_W     = X_W - MULT_SHIFT;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32'd16777216);

  // Contact status codes
  localparam logic [1:0] ST_INACTIVE = 2'd0;
  localparam logic [1:0] ST_STICK    = 2'd1;
  localparam logic [1:0] ST_SLIP     = 2'd2;

  typedef struct packed {
    logic [GAP_W-1:0] gap_x;
    logic [GAP_W-1:0] gap_y;
    logic [GAP_W-1:0] gap_z;
    logic [MU_W-1:0]  friction_coeff;
    logic [PRS_W-1:0] pressure;
  } in_item_t;

  typedef struct packed {
    logic [GAP_W-1:0] mult_x;
    logic [GAP_W-1:0] mult_y;
    logic [GAP_W-1:0] mult_z;
    logic [GAP_W-1:0] ret_gap_x;
    logic [GAP_W-1:0] ret_gap_y;
    logic [GAP_W-1:0] ret_gap_z;
    logic [1:0]       contact_status;
    logic             overflow;
  } out_item_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic                            active;
    logic [MAX_DIM-1:0][GAP_W-1:0]   gap;
    logic [SUM_W-1:0]                sum;
    logic [CAP_W-1:0]                cap;
    logic [LSQ_W-1:0]                lsq;
  } qent_t;

endpackage

### rtl/core/fesr_chan.sv
// Valid/ready channel interface carrying one payload type.
interface fesr_chan #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/fesr_front.sv
// Front end: takes transactions, forms squares, capacity and stick bound.
module fesr_front #(
  parameter int VECTOR_DIM = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [fesr_pkg::LEN_W-1:0] len,
  fesr_chan.sink                     item,
  input  logic                       q_full,
  output logic                       ent_valid,
  output fesr_pkg::qent_t            ent
);
  import fesr_pkg::*;

  logic                          fe;
  logic                          f1_v;
  logic                          f2_v;
  logic                          f1_active;
  logic [MAX_DIM-1:0][GAP_W-1:0] f1_gap;
  logic [MAX_DIM-1:0][SUM_W-1:0] f1_sq;
  logic [CAP_W-1:0]              f1_cap;
  logic [LSQ_W-1:0]              f1_lsq;
  logic [MAX_DIM-1:0][GAP_W-1:0] gap_in;
  logic [MAX_DIM-1:0][GAP_W-1:0] gap_w;
  logic [MAX_DIM-1:0][SUM_W-1:0] sq_w;
  logic [SUM_W-1:0]              sum_w;

  // Stall only when the last stage holds an item the queue cannot take
  assign fe         = !(f2_v && q_full);
  assign item.ready = fe;
  assign ent_valid  = f2_v;

  assign gap_in[0] = item.data.gap_x;
  assign gap_in[1] = item.data.gap_y;
  assign gap_in[2] = item.data.gap_z;

  // Per-lane squares; a signed square equals the magnitude squared
  always_comb begin
    logic signed [SUM_W-1:0] prod;
    for (int i = 0; i < MAX_DIM; i++) begin
      prod = $signed(gap_in[i]) * $signed(gap_in[i]);
      if (i < VECTOR_DIM) begin
        gap_w[i] = gap_in[i];
        sq_w[i]  = SUM_W'(prod);
      end else begin
        gap_w[i] = '0;
        sq_w[i]  = '0;
      end
    end
  end

  always_comb begin
    sum_w = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      sum_w = sum_w + f1_sq[i];
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else if (fe) begin
      f1_v <= item.valid;
      f2_v <= f1_v;
    end
  end

  // Products stage
  always_ff @(posedge clk) begin
    if (fe) begin
      f1_active <= (item.data.friction_coeff != '0) && (item.data.pressure != '0);
      f1_gap    <= gap_w;
      f1_sq     <= sq_w;
      f1_cap    <= CAP_W'(CAP_W'(item.data.friction_coeff) * CAP_W'(item.data.pressure));
      f1_lsq    <= LSQ_W'(LSQ_W'(len) * LSQ_W'(len));
    end
  end

  // Sum stage, feeds the queue
  always_ff @(posedge clk) begin
    if (fe) begin
      ent.active <= f1_active;
      ent.gap    <= f1_gap;
      ent.sum    <= sum_w;
      ent.cap    <= f1_cap;
      ent.lsq    <= f1_lsq;
    end
  end

endmodule

### rtl/core/fesr_queue.sv
// Short FIFO between the front end and the back end.
module fesr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fesr_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output fesr_pkg::qent_t pop_data,
  output logic            empty
);
  import fesr_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  qent_t         mem [QUEUE_DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;
  logic          wr;
  logic          rd;

  assign full     = (cnt == (AW + 1)'(QUEUE_DEPTH));
  assign empty    = (cnt == '0);
  assign wr       = push && !full;
  assign rd       = pop && !empty;
  assign pop_data = mem[rp];

  // Storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + AW'(1);
      end
      if (rd) begin
        rp <= rp + AW'(1);
      end
      cnt <= cnt + (AW + 1)'(wr) - (AW + 1)'(rd);
    end
  end

endmodule

### rtl/core/fesr_back.sv
// Back end: stick test, square root, unit vector divide, scaling and saturation.
module fesr_back #(
  parameter int VECTOR_DIM = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [fesr_pkg::LEN_W-1:0] len,
  input  logic                       q_empty,
  input  fesr_pkg::qent_t            q_data,
  output logic                       q_pop,
  fesr_chan.source                   result
);
  import fesr_pkg::*;

  typedef struct packed {
    logic                          stick;
    logic                          active;
    logic [MAX_DIM-1:0][GAP_W-1:0] gap;
    logic [MAX_DIM-1:0][MAG_W-1:0] mag;
    logic [HALF_W-1:0]             half;
    logic [CAP_W-1:0]              cap;
  } sqc_t;

  typedef struct packed {
    logic                          stick;
    logic                          active;
    logic [MAX_DIM-1:0][GAP_W-1:0] gap;
    logic [CAP_W-1:0]              cap;
  } dvc_t;

  localparam logic [MAGX_W-1:0] POS_LIM = MAGX_W'(32'h7FFF_FFFF);
  localparam logic [MAGX_W-1:0] NEG_LIM = POS_LIM + MAGX_W'(1);

  logic be;

  // Whole back pipe advances when the output register is free
  assign be    = !result.valid || result.ready;
  assign q_pop = be && !q_empty;

  // ---------------- entry: stick test and normalization ----------------
  logic [SUM_W-1:0]  nrm_t;
  logic [HALF_W-1:0] nrm_h;
  sqc_t              b0_c;

  always_comb begin
    nrm_t = q_data.sum;
    nrm_h = '0;
    if (nrm_t[SUM_W-1 -: 32] == '0) begin
      nrm_t    = nrm_t << 32;
      nrm_h[4] = 1'b1;
    end
    if (nrm_t[SUM_W-1 -: 16] == '0) begin
      nrm_t    = nrm_t << 16;
      nrm_h[3] = 1'b1;
    end
    if (nrm_t[SUM_W-1 -: 8] == '0) begin
      nrm_t    = nrm_t << 8;
      nrm_h[2] = 1'b1;
    end
    if (nrm_t[SUM_W-1 -: 4] == '0) begin
      nrm_t    = nrm_t << 4;
      nrm_h[1] = 1'b1;
    end
    if (nrm_t[SUM_W-1 -: 2] == '0) begin
      nrm_t    = nrm_t << 2;
      nrm_h[0] = 1'b1;
    end
  end

  always_comb begin
    b0_c.stick  = (q_data.sum <= SUM_W'(q_data.lsq));
    b0_c.active = q_data.active;
    b0_c.gap    = q_data.gap;
    b0_c.half   = nrm_h;
    b0_c.cap    = q_data.cap;
    for (int i = 0; i < MAX_DIM; i++) begin
      b0_c.mag[i] = q_data.gap[i][GAP_W-1] ? (~q_data.gap[i] + MAG_W'(1)) : q_data.gap[i];
    end
  end

  // ---------------- square root pipeline ----------------
  logic             sq_v [SQRT_STEPS+1];
  sqc_t             sq_c [SQRT_STEPS+1];
  logic [SUM_W-1:0] sq_n [SQRT_STEPS+1];
  logic [SUM_W-1:0] sq_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (be) begin
      sq_v[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      sq_c[0] <= b0_c;
      sq_n[0] <= nrm_t;
      sq_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic [SUM_W-1:0] trial;
    logic             take;

    assign trial = sq_r[k] + BIT;
    assign take  = (sq_n[k] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (be) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    // One root bit per stage
    always_ff @(posedge clk) begin
      if (be) begin
        sq_c[k+1] <= sq_c[k];
        sq_n[k+1] <= take ? (sq_n[k] - trial) : sq_n[k];
        sq_r[k+1] <= take ? ((sq_r[k] >> 1) + BIT) : (sq_r[k] >> 1);
      end
    end
  end

  // ---------------- restoring divider pipeline ----------------
  logic             dv_v   [DIV_STEPS];
  dvc_t             dv_c   [DIV_STEPS];
  logic [DEN_W-1:0] dv_d   [DIV_STEPS];
  logic [NUM_W-1:0] dv_rem [DIV_STEPS][VECTOR_DIM];
  logic [U_W-1:0]   dv_q   [DIV_STEPS][VECTOR_DIM];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic             v_in;
    dvc_t             c_in;
    logic [DEN_W-1:0] d_in;
    logic [NUM_W-1:0] r_in  [VECTOR_DIM];
    logic [U_W-1:0]   q_in  [VECTOR_DIM];
    logic [NUM_W-1:0] r_out [VECTOR_DIM];
    logic [U_W-1:0]   q_out [VECTOR_DIM];

    if (j == 0) begin : g_first
      // Divisor is the slip length on stick, the root on slip
      always_comb begin
        v_in        = sq_v[SQRT_STEPS];
        c_in.stick  = sq_c[SQRT_STEPS].stick;
        c_in.active = sq_c[SQRT_STEPS].active;
        c_in.gap    = sq_c[SQRT_STEPS].gap;
        c_in.cap    = sq_c[SQRT_STEPS].cap;
        d_in = sq_c[SQRT_STEPS].stick ? DEN_W'(len) : sq_r[SQRT_STEPS][DEN_W-1:0];
        for (int i = 0; i < VECTOR_DIM; i++) begin
          r_in[i] = sq_c[SQRT_STEPS].stick ? NUM_W'(sq_c[SQRT_STEPS].mag[i])
                  : (NUM_W'(sq_c[SQRT_STEPS].mag[i]) << sq_c[SQRT_STEPS].half);
          q_in[i] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        v_in = dv_v[j-1];
        c_in = dv_c[j-1];
        d_in = dv_d[j-1];
        for (int i = 0; i < VECTOR_DIM; i++) begin
          r_in[i] = {dv_rem[j-1][i][NUM_W-2:0], 1'b0};
          q_in[i] = dv_q[j-1][i];
        end
      end
    end

    // One quotient bit per stage and lane
    always_comb begin
      for (int i = 0; i < VECTOR_DIM; i++) begin
        q_out[i] = q_in[i];
        if (r_in[i] >= NUM_W'(d_in)) begin
          r_out[i]              = r_in[i] - NUM_W'(d_in);
          q_out[i][U_W-1-j]     = 1'b1;
        end else begin
          r_out[i]              = r_in[i];
          q_out[i][U_W-1-j]     = 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (be) begin
        dv_v[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (be) begin
        dv_c[j] <= c_in;
        dv_d[j] <= d_in;
        for (int i = 0; i < VECTOR_DIM; i++) begin
          dv_rem[j][i] <= r_out[i];
          dv_q[j][i]   <= q_out[i];
        end
      end
    end
  end

  // ---------------- scaling ----------------
  logic             m1_v;
  dvc_t             m1_c;
  logic [PH_W-1:0]  m1_ph [VECTOR_DIM];
  logic [PL_W-1:0]  m1_pl [VECTOR_DIM];
  logic [PG_W-1:0]  m1_pg [VECTOR_DIM];
  logic             m2_v;
  dvc_t             m2_c;
  logic [X_W-1:0]   m2_x  [VECTOR_DIM];
  logic [GAP_W-1:0] m2_rg [VECTOR_DIM];
  logic             o_v;
  out_item_t        o_data;
  out_item_t        o_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      o_v  <= 1'b0;
    end else if (be) begin
      m1_v <= dv_v[DIV_STEPS-1];
      m2_v <= m1_v;
      o_v  <= m2_v;
    end
  end

  // Partial products of capacity times unit factor, and slip length times unit factor
  always_ff @(posedge clk) begin
    if (be) begin
      m1_c <= dv_c[DIV_STEPS-1];
      for (int i = 0; i < VECTOR_DIM; i++) begin
        m1_ph[i] <= PH_W'(dv_c[DIV_STEPS-1].cap[CAP_W-1:CAP_LO_W]) *
                    PH_W'(dv_q[DIV_STEPS-1][i]);
        m1_pl[i] <= PL_W'(dv_c[DIV_STEPS-1].cap[CAP_LO_W-1:0]) *
                    PL_W'(dv_q[DIV_STEPS-1][i]);
        m1_pg[i] <= PG_W'(len) * PG_W'(dv_q[DIV_STEPS-1][i]);
      end
    end
  end

  // Combine partial products
  always_ff @(posedge clk) begin
    if (be) begin
      m2_c <= m1_c;
      for (int i = 0; i < VECTOR_DIM; i++) begin
        m2_x[i]  <= X_W'(m1_ph[i]) + X_W'(m1_pl[i] >> CAP_LO_W);
        m2_rg[i] <= m1_pg[i][PG_W-1:UNIT_BITS];
      end
    end
  end

  // Saturate, apply sign, assemble result
  always_comb begin
    logic [MAX_DIM-1:0][GAP_W-1:0] mw;
    logic [MAX_DIM-1:0][GAP_W-1:0] rw;
    logic [MAGX_W-1:0]             mg;
    logic [MAGX_W-1:0]             lim;
    logic [GAP_W-1:0]              mm;
    logic                          neg;
    logic                          sat;
    logic                          ovf;
    mw  = '0;
    rw  = '0;
    ovf = 1'b0;
    for (int i = 0; i < VECTOR_DIM; i++) begin
      neg = m2_c.gap[i][GAP_W-1];
      mg  = m2_x[i][X_W-1:MULT_SHIFT];
      lim = neg ? NEG_LIM : POS_LIM;
      sat = (mg > lim);
      mm  = sat ? lim[GAP_W-1:0] : mg[GAP_W-1:0];
      ovf = ovf | sat;
      mw[i] = neg ? (~mm + GAP_W'(1)) : mm;
      if (m2_c.stick) begin
        rw[i] = m2_c.gap[i];
      end else begin
        rw[i] = neg ? (~m2_rg[i] + GAP_W'(1)) : m2_rg[i];
      end
    end
    if (m2_c.active) begin
      o_next.mult_x         = mw[0];
      o_next.mult_y         = mw[1];
      o_next.mult_z         = mw[2];
      o_next.ret_gap_x      = rw[0];
      o_next.ret_gap_y      = rw[1];
      o_next.ret_gap_z      = rw[2];
      o_next.contact_status = m2_c.stick ? ST_STICK : ST_SLIP;
      o_next.overflow       = ovf;
    end else begin
      o_next                = '0;
      o_next.contact_status = ST_INACTIVE;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (be) begin
      o_data <= o_next;
    end
  end

  assign result.valid = o_v;
  assign result.data  = o_data;

endmodule

### rtl/core/friction_elastic_slip_return.sv
// Top level: Coulomb friction radial return per contact point, fixed point.
// Throughput: one transaction per cycle while the result is not stalled; depth is set
// by the 32-stage square root and the 31-stage divider in the back end, decoupled from
// the front by a 4-entry queue.
// Reset (rst, synchronous): pipelines and queue empty, slip length 1.0 (Q7.24).
module friction_elastic_slip_return #(
  parameter int VECTOR_DIM = 3
) (
  input  logic     clk,
  input  logic     rst,
  fesr_chan.sink   cfg,
  fesr_chan.sink   item,
  fesr_chan.source result
);
  import fesr_pkg::*;

  logic [LEN_W-1:0] elastic_slip_length;
  logic [LEN_W-1:0] len_eff;
  logic             f_valid;
  qent_t            f_ent;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  qent_t            q_data;

  // Configuration register; always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      elastic_slip_length <= LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      elastic_slip_length <= LEN_W'(cfg.data);
    end
  end

  // A zero slip length acts as one LSB
  assign len_eff = (elastic_slip_length == '0) ? LEN_W'(1) : elastic_slip_length;

  fesr_front #(.VECTOR_DIM(VECTOR_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .len       (len_eff),
    .item      (item),
    .q_full    (q_full),
    .ent_valid (f_valid),
    .ent       (f_ent)
  );

  fesr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (f_ent),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  fesr_back #(.VECTOR_DIM(VECTOR_DIM)) u_back (
    .clk     (clk),
    .rst     (rst),
    .len     (len_eff),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

### rtl/core/fesr_check.sv
// Port-level checker for the friction elastic slip return block, with its bind.
module fesr_check (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_ready,
  input fesr_pkg::out_item_t  res_data
);
  import fesr_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // Inactive contact gives an all-zero result
  a_inactive: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.contact_status == ST_INACTIVE) |->
      (res_data.mult_x == '0) && (res_data.mult_y == '0) && (res_data.mult_z == '0) &&
      (res_data.ret_gap_x == '0) && (res_data.ret_gap_y == '0) &&
      (res_data.ret_gap_z == '0) && !res_data.overflow)
    else $error("inactive result not zero");

  // Overflow flag only with a saturated multiplier component
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.overflow |->
      (res_data.mult_x == 32'h7FFF_FFFF) || (res_data.mult_x == 32'h8000_0000) ||
      (res_data.mult_y == 32'h7FFF_FFFF) || (res_data.mult_y == 32'h8000_0000) ||
      (res_data.mult_z == 32'h7FFF_FFFF) || (res_data.mult_z == 32'h8000_0000))
    else $error("overflow without saturated multiplier");

  // No result right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid after reset");

endmodule

bind friction_elastic_slip_return fesr_check u_check (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);

### tb/tb_pkg.sv
`timescale 1ns / 1ps
// Shared testbench constants for the friction slip return bench.
package tb_pkg;
  localparam int CLK_HALF      = 6;
  localparam int DRAIN_CYCLES  = 100;
  localparam int LONG_HOLD     = 200;
endpackage

### tb/tb.sv
`timescale 1ns / 1ps
// Top-level bench: drives contact points and checks the radial return results.
module tb;
  import fesr_pkg::*;
  import tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fesr_chan #(.T(logic [LEN_W-1:0])) cfg_ch ();
  fesr_chan #(.T(in_item_t))         item_ch ();
  fesr_chan #(.T(out_item_t))        res_ch ();

  friction_elastic_slip_return #(.VECTOR_DIM(3)) dut (
    .clk(clk), .rst(rst), .cfg(cfg_ch.sink), .item(item_ch.sink), .result(res_ch.source)
  );

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  logic [LEN_W-1:0] slip_len;
  out_item_t        expected_q[$];
  int               fail_cnt = 0;
  int               rx_idle = 0;
  bit               stall_on = 1'b1;
  bit               hold_rx = 1'b0;

  // Square root by digit recurrence
  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Expected result for one contact point
  function automatic out_item_t predict_contact(input in_item_t it);
    out_item_t o;
    logic [31:0] g[3];
    logic [63:0] m[3];
    logic [63:0] u[3];
    bit          ng[3];
    logic [63:0] cap, s, len, t, n, gm, x, mg, lim, hq;
    int          half;
    o = '0;
    g[0] = it.gap_x; g[1] = it.gap_y; g[2] = it.gap_z;
    if (it.friction_coeff == 0 || it.pressure == 0) return o;
    len = (slip_len == 0) ? 64'd1 : 64'(slip_len);
    cap = 64'(it.friction_coeff) * 64'(it.pressure);
    s = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = g[i][31];
      m[i] = ng[i] ? (64'd1 << 32) - 64'(g[i]) : 64'(g[i]);
      s = s + m[i] * m[i];
    end
    o.ret_gap_x = '0; o.ret_gap_y = '0; o.ret_gap_z = '0;
    if (s <= len * len) begin
      for (int i = 0; i < 3; i++) u[i] = (m[i] << 30) / len;
      o.ret_gap_x = g[0]; o.ret_gap_y = g[1]; o.ret_gap_z = g[2];
      o.contact_status = ST_STICK;
    end else begin
      half = 0;
      t = s;
      while (t < (64'd1 << 62)) begin
        t = t << 2;
        half++;
      end
      n = root64(t);
      for (int i = 0; i < 3; i++) begin
        gm = m[i] << half;
        u[i] = (gm << 30) / n;
        mg = (len * u[i]) >> 30;
        g[i] = ng[i] ? 32'((64'd1 << 32) - mg) : 32'(mg);
      end
      o.ret_gap_x = g[0]; o.ret_gap_y = g[1]; o.ret_gap_z = g[2];
      o.contact_status = ST_SLIP;
    end
    for (int i = 0; i < 3; i++) begin
      x = (cap >> 24) * u[i] + (((cap & 64'hFFFFFF) * u[i]) >> 24);
      mg = x >> 18;
      lim = ng[i] ? (64'd1 << 31) : (64'd1 << 31) - 1;
      if (mg > lim) begin
        mg = lim;
        o.overflow = 1'b1;
      end
      hq = ng[i] ? ((64'd1 << 32) - mg) : mg;
      g[i] = hq[31:0];
    end
    o.mult_x = g[0]; o.mult_y = g[1]; o.mult_z = g[2];
    return o;
  endfunction

  // Result checker and receiver stalls
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_cnt++;
        end else begin
          e = expected_q.pop_front();
          if (res_ch.data.mult_x !== e.mult_x) begin
            $error("mult_x exp %h got %h", e.mult_x, res_ch.data.mult_x); fail_cnt++;
          end
          if (res_ch.data.mult_y !== e.mult_y) begin
            $error("mult_y exp %h got %h", e.mult_y, res_ch.data.mult_y); fail_cnt++;
          end
          if (res_ch.data.mult_z !== e.mult_z) begin
            $error("mult_z exp %h got %h", e.mult_z, res_ch.data.mult_z); fail_cnt++;
          end
          if (res_ch.data.ret_gap_x !== e.ret_gap_x) begin
            $error("ret_gap_x exp %h got %h", e.ret_gap_x, res_ch.data.ret_gap_x); fail_cnt++;
          end
          if (res_ch.data.ret_gap_y !== e.ret_gap_y) begin
            $error("ret_gap_y exp %h got %h", e.ret_gap_y, res_ch.data.ret_gap_y); fail_cnt++;
          end
          if (res_ch.data.ret_gap_z !== e.ret_gap_z) begin
            $error("ret_gap_z exp %h got %h", e.ret_gap_z, res_ch.data.ret_gap_z); fail_cnt++;
          end
          if (res_ch.data.contact_status !== e.contact_status) begin
            $error("contact_status exp %0d got %0d", e.contact_status,
                   res_ch.data.contact_status); fail_cnt++;
          end
          if (res_ch.data.overflow !== e.overflow) begin
            $error("overflow exp %0d got %0d", e.overflow, res_ch.data.overflow); fail_cnt++;
          end
        end
      end
      // Receiver idles in random bursts
      if (rx_idle == 0 && stall_on && $urandom_range(0, 4) == 0)
        rx_idle = $urandom_range(1, 3);
      res_ch.ready <= !hold_rx && (rx_idle == 0);
      if (rx_idle != 0) rx_idle--;
    end
  end

  // Long receiver hold-off, counted in cycles
  task automatic hold_receiver();
    hold_rx = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_rx = 1'b0;
  endtask

  // Sends one contact point, with an optional random gap first
  task automatic send_contact(input in_item_t it);
    if (stall_on && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    expected_q.push_back(predict_contact(it));
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_slip_length(input logic [LEN_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    slip_len = v;
  endtask

  function automatic in_item_t mk(input logic [31:0] x, y, z, input logic [15:0] mu,
                                  input logic [31:0] p);
    in_item_t it;
    it.gap_x = x; it.gap_y = y; it.gap_z = z; it.friction_coeff = mu; it.pressure = p;
    return it;
  endfunction

  // Random gap: sometimes small, sometimes full range, sometimes an extreme value
  function automatic logic [31:0] rnd_gap();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 33554432)) - 16777216);
      2:       return 32'($signed($urandom_range(0, 512)) - 256);
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic in_item_t rnd_contact();
    logic [15:0] mu;
    logic [31:0] p;
    mu = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
    p  = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
    if ($urandom_range(0, 7) == 0) mu = 16'hFFFF;
    return mk(rnd_gap(), rnd_gap(), rnd_gap(), mu, p);
  endfunction

  task automatic test_directed();
    send_contact(mk(32'h0100_0000, 0, 0, 16'd0, 32'h0001_0000));   // inactive, mu zero
    send_contact(mk(32'h0100_0000, 0, 0, 16'h1000, 32'd0));        // inactive, p zero
    send_contact(mk(0, 0, 0, 16'h1000, 32'h0001_0000));            // zero gap
    send_contact(mk(32'h0080_0000, 32'hFF80_0000, 0, 16'h1000, 32'h0001_0000));
    send_contact(mk(32'h0100_0000, 0, 0, 16'h1000, 32'h0001_0000)); // on the cone
    send_contact(mk(32'h0100_0001, 0, 0, 16'h1000, 32'h0001_0000));
    send_contact(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_contact(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 32'hFFFF_FFFF));
    send_contact(mk(32'h8000_0000, 0, 32'h0000_0001, 16'h0001, 32'h0000_0001));
    send_contact(mk(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 16'hFFFF, 32'h0001_0000));
    send_contact(mk(0, 0, 32'h8000_0000, 16'h8000, 32'h8000_0000));
  endtask

  task automatic test_slip_lengths();
    logic [LEN_W-1:0] lens[5];
    lens = '{31'd0, 31'd1, 31'h7FFF_FFFF, 31'd4096, LEN_RESET};
    foreach (lens[k]) begin
      wait_drained();
      write_slip_length(lens[k]);
      repeat (20) send_contact(rnd_contact());
      send_contact(mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 16'hFFFF, 32'hFFFF_FFFF));
    end
  endtask

  // Enough transactions to fill the pipeline and queue while the receiver holds off
  task automatic test_backpressure();
    fork
      hold_receiver();
      repeat (120) send_contact(rnd_contact());
    join
    wait_drained();
    repeat (10) send_contact(rnd_contact());
  endtask

  task automatic test_random();
    repeat (200) send_contact(rnd_contact());
    wait_drained();
    write_slip_length(31'($urandom_range(1, 32'h7FFF_FFFF)));
    repeat (60) send_contact(rnd_contact());
    stall_on = 1'b0;
    repeat (60) send_contact(rnd_contact());
  endtask

  initial begin
    slip_len = LEN_RESET;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    item_ch.valid = 1'b0; item_ch.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_slip_lengths();
    test_backpressure();
    test_random();
    wait_drained();
    if (fail_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Timeout
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

### friction_elastic_slip_return.f
rtl/core/fesr_pkg.sv
rtl/core/fesr_chan.sv
rtl/core/fesr_front.sv
rtl/core/fesr_queue.sv
rtl/core/fesr_back.sv
rtl/core/friction_elastic_slip_return.sv
rtl/core/fesr_check.sv
tb/tb_pkg.sv
tb/tb.sv
